/* src/gzhp_pkg.sv */
// Shared types and constants for the gzip header parser.
// Depends on nothing; every other file imports it.
`default_nettype none

package gzhp_pkg;

  localparam logic [7:0] Id1       = 8'h1f;
  localparam logic [7:0] Id2       = 8'h8b;
  localparam logic [7:0] CmDeflate = 8'h08;

  localparam logic [7:0] FlgHcrc    = 8'h02;
  localparam logic [7:0] FlgExtra   = 8'h04;
  localparam logic [7:0] FlgName    = 8'h08;
  localparam logic [7:0] FlgComment = 8'h10;

  localparam int FixedSize   = 10;
  localparam int TrailerSize = 8;
  localparam int MinStream   = FixedSize + TrailerSize;
  localparam int QueueDepth  = 2;

  typedef enum logic [3:0] {
    PH_WAIT    = 4'd0,
    PH_FIXED   = 4'd1,
    PH_XLEN_LO = 4'd2,
    PH_XLEN_HI = 4'd3,
    PH_EXTRA   = 4'd4,
    PH_NAME    = 4'd5,
    PH_COMMENT = 4'd6,
    PH_CRC_LO  = 4'd7,
    PH_CRC_HI  = 4'd8,
    PH_PAYLOAD = 4'd9,
    PH_ERROR   = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    K_HEADER    = 3'd0,
    K_LAST      = 3'd1,
    K_PAYLOAD   = 3'd2,
    K_MALFORMED = 3'd3,
    K_DROPPED   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [31:0] stream_length;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [31:0] header_length;
    logic [7:0]  header_flags;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [31:0] stream_length;
    logic        is_id1;
    logic        is_id2;
    logic        is_deflate;
    logic        is_zero;
  } class_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

/* src/gzip_header_parser.sv */
// Top level of the gzip member header parser: front tagger, queue, and
// header phase machine with its result queue. Depends on gzhp_pkg,
// gzhp_front and gzhp_back.
//
//   channel  | ports                      | moves
//   ---------+----------------------------+--------------------------------
//   input    | push, full, item           | one stream byte with length
//   result   | empty, pop, result         | one classified byte per item
//
// One item per cycle sustained while neither queue stalls; the header phase update is combinational.
// A result shows on the result ports after its item has passed the front queue and then the result queue.
// Two-entry queues between the front, the phase machine and the result side
// let either side stall without stopping the other.
// Reset (rst, synchronous) empties both queues and puts the parser in wait.
`default_nettype none

module gzip_header_parser
  import gzhp_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     result
);

  q_status_t front_status;
  q_status_t back_status;
  class_t    cls;
  logic      cls_pop;

  gzhp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .status  (front_status),
    .cls_pop (cls_pop),
    .cls     (cls)
  );

  gzhp_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cls       (cls),
    .cls_empty (front_status.empty),
    .cls_pop   (cls_pop),
    .pop       (pop),
    .result    (result),
    .status    (back_status)
  );

  assign full  = front_status.full;
  assign empty = back_status.empty;

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_hlen_only_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind != K_LAST |-> result.header_length == 32'h0)
    else $error("header length outside last header byte");

  a_pay_only_payload: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind != K_PAYLOAD |-> result.payload_byte == 8'h00)
    else $error("payload byte outside payload result");

endmodule

`default_nettype wire

/* src/gzhp_fifo.sv */
// Small register queue with push/pop and full/empty status.
// Depends on gzhp_pkg for the status struct.
`default_nettype none

module gzhp_fifo
  import gzhp_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output q_status_t             status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !status.empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* src/gzhp_front.sv */
// Front end: accepts input items, tags magic, method and zero bytes,
// and queues them for the parser. Depends on gzhp_pkg and gzhp_fifo.
`default_nettype none

module gzhp_front
  import gzhp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire in_item_t  item,
  output q_status_t      status,
  input  wire logic      cls_pop,
  output class_t         cls
);

  class_t                  tagged_item;
  logic [$bits(class_t)-1:0] q_rd;

  always_comb begin
    tagged_item.data_byte     = item.data_byte;
    tagged_item.first_byte    = item.first_byte;
    tagged_item.stream_length = item.stream_length;
    tagged_item.is_id1        = (item.data_byte == Id1);
    tagged_item.is_id2        = (item.data_byte == Id2);
    tagged_item.is_deflate    = (item.data_byte == CmDeflate);
    tagged_item.is_zero       = (item.data_byte == 8'h00);
  end

  gzhp_fifo #(
    .WIDTH ($bits(class_t)),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (tagged_item),
    .rd_en   (cls_pop),
    .rd_data (q_rd),
    .status  (status)
  );

  assign cls = class_t'(q_rd);

endmodule

`default_nettype wire

/* src/gzhp_back.sv */
// Back end: header phase machine, one tagged item per cycle while the result queue has room, results
// queued for the output side. Depends on gzhp_pkg and gzhp_fifo.
`default_nettype none

module gzhp_back
  import gzhp_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire class_t cls,
  input  wire logic   cls_empty,
  output logic        cls_pop,
  input  wire logic   pop,
  output out_item_t   result,
  output q_status_t   status
);

  localparam int LB = LENGTH_BITS;
  localparam int EW = (LB > 32) ? LB : 32;

  phase_t        phase, phase_next, cur_phase, ph_hdr;
  logic [LB-1:0] pos, pos_next, cur_pos, pos_inc;
  logic [LB-1:0] total, total_next, cur_total, len_lb;
  logic [7:0]    flags, flags_next, cur_flags, flags_hdr;
  logic [7:0]    xlo, xlo_next, cur_xlo, xlo_hdr;
  logic [15:0]   skip, skip_next, cur_skip, skip_hdr, skip_dec;
  logic [EW-1:0] len_ext, hlen_ext;
  logic          short_len, first_short, active, hdr_ok, take;
  out_item_t     res;
  logic [$bits(out_item_t)-1:0] q_rd;

  function automatic phase_t next_field(phase_t done, logic [7:0] f);
    phase_t r;
    if (done < PH_XLEN_LO && (f & FlgExtra) != 8'h00) begin
      r = PH_XLEN_LO;
    end else if (done < PH_NAME && (f & FlgName) != 8'h00) begin
      r = PH_NAME;
    end else if (done < PH_COMMENT && (f & FlgComment) != 8'h00) begin
      r = PH_COMMENT;
    end else if (done < PH_CRC_LO && (f & FlgHcrc) != 8'h00) begin
      r = PH_CRC_LO;
    end else begin
      r = PH_PAYLOAD;
    end
    return r;
  endfunction

  assign take    = !cls_empty && !status.full;
  assign cls_pop = take;

  assign len_ext     = EW'(cls.stream_length);
  assign len_lb      = len_ext[LB-1:0];
  assign short_len   = (len_lb < LB'(MinStream));
  assign first_short = cls.first_byte && short_len;

  always_comb begin
    if (cls.first_byte) begin
      cur_phase = PH_FIXED;
      cur_pos   = '0;
      cur_total = len_lb;
      cur_flags = 8'h00;
      cur_xlo   = 8'h00;
      cur_skip  = 16'h0000;
    end else begin
      cur_phase = phase;
      cur_pos   = pos;
      cur_total = total;
      cur_flags = flags;
      cur_xlo   = xlo;
      cur_skip  = skip;
    end
  end

  assign pos_inc  = cur_pos + LB'(1);
  assign skip_dec = cur_skip - 16'd1;
  assign active   = !first_short && cur_phase != PH_WAIT && cur_phase != PH_ERROR &&
                    (cur_pos < cur_total);
  assign hlen_ext = EW'(pos_inc);

  always_comb begin
    hdr_ok    = 1'b1;
    ph_hdr    = cur_phase;
    flags_hdr = cur_flags;
    xlo_hdr   = cur_xlo;
    skip_hdr  = cur_skip;
    unique case (cur_phase)
      PH_FIXED: begin
        if ((cur_pos == LB'(0) && !cls.is_id1) ||
            (cur_pos == LB'(1) && !cls.is_id2) ||
            (cur_pos == LB'(2) && !cls.is_deflate)) begin
          hdr_ok = 1'b0;
        end else begin
          if (cur_pos == LB'(3)) begin
            flags_hdr = cls.data_byte;
          end
          if (cur_pos >= LB'(FixedSize - 1)) begin
            ph_hdr = next_field(PH_FIXED, flags_hdr);
          end
        end
      end
      PH_XLEN_LO: begin
        xlo_hdr = cls.data_byte;
        ph_hdr  = PH_XLEN_HI;
      end
      PH_XLEN_HI: begin
        skip_hdr = {cls.data_byte, cur_xlo};
        ph_hdr   = (skip_hdr != 16'h0000) ? PH_EXTRA : next_field(PH_EXTRA, cur_flags);
      end
      PH_EXTRA: begin
        skip_hdr = skip_dec;
        if (skip_dec == 16'h0000) begin
          ph_hdr = next_field(PH_EXTRA, cur_flags);
        end
      end
      PH_NAME, PH_COMMENT: begin
        if (cls.is_zero) begin
          ph_hdr = next_field(cur_phase, cur_flags);
        end
      end
      PH_CRC_LO: ph_hdr = PH_CRC_HI;
      default:   ph_hdr = PH_PAYLOAD;
    endcase
  end

  always_comb begin
    phase_next = cur_phase;
    pos_next   = cur_pos;
    total_next = cur_total;
    flags_next = cur_flags;
    xlo_next   = cur_xlo;
    skip_next  = cur_skip;
    if (first_short) begin
      phase_next = PH_ERROR;
      pos_next   = LB'(1);
    end else if (active) begin
      pos_next = pos_inc;
      if (cur_phase != PH_PAYLOAD) begin
        flags_next = flags_hdr;
        xlo_next   = xlo_hdr;
        skip_next  = skip_hdr;
        if (hdr_ok && ph_hdr == PH_PAYLOAD) begin
          phase_next = PH_PAYLOAD;
        end else if (!hdr_ok || pos_inc >= cur_total) begin
          phase_next = PH_ERROR;
        end else begin
          phase_next = ph_hdr;
        end
      end
    end
  end

  always_comb begin
    res.kind          = K_DROPPED;
    res.payload_byte  = 8'h00;
    res.header_length = 32'h0;
    res.header_flags  = flags_next;
    if (first_short) begin
      res.kind = K_MALFORMED;
    end else if (active) begin
      if (cur_phase == PH_PAYLOAD) begin
        res.kind         = K_PAYLOAD;
        res.payload_byte = cls.data_byte;
      end else if (hdr_ok && ph_hdr == PH_PAYLOAD) begin
        res.kind          = K_LAST;
        res.header_length = hlen_ext[31:0];
      end else if (!hdr_ok || pos_inc >= cur_total) begin
        res.kind = K_MALFORMED;
      end else begin
        res.kind = K_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      pos   <= '0;
      total <= '0;
      flags <= 8'h00;
      xlo   <= 8'h00;
      skip  <= 16'h0000;
    end else if (take) begin
      phase <= phase_next;
      pos   <= pos_next;
      total <= total_next;
      flags <= flags_next;
      xlo   <= xlo_next;
      skip  <= skip_next;
    end
  end

  gzhp_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QueueDepth)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (q_rd),
    .status  (status)
  );

  assign result = out_item_t'(q_rd);

endmodule

`default_nettype wire
